/* hdl/assert_macros.svh */
// Assertion helpers. Both expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

/* hdl/spky_pkg.sv */
`timescale 1ns / 1ps
package spky_pkg;

  localparam int unsigned NWords        = 12;
  localparam int unsigned QueueDepthDef = 4;
  localparam logic [3:0]  LastStep      = 4'(NWords - 1);
  localparam logic [1:0]  LastRound     = 2'd2;
  localparam logic [63:0] SeedConst     = 64'hdeadbeefdeadbeef;

  typedef enum logic [1:0] {
    CFG_SEED_LOW  = 2'd0,
    CFG_SEED_HIGH = 2'd1
  } spky_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_TAIL,
    ST_END,
    ST_DONE
  } spky_state_e;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } spky_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } spky_out_t;

  // One classified word handed from the front end to the engine.
  typedef struct packed {
    logic [63:0] word;       // masked data
    logic [3:0]  pos;        // slot in the current block
    logic        first;      // opens a message
    logic        stored;     // carries at least one byte
    logic        completes;  // fills the block
    logic        last;
    logic [3:0]  tail_words; // stored words in the tail block
    logic [6:0]  tail_len;   // tail length in bytes
  } spky_entry_t;

  function automatic logic [63:0] spky_rotl(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] t;
    t = {x, x} << r;
    return t[127:64];
  endfunction

  function automatic logic [5:0] mix_rot(input logic [3:0] i);
    logic [5:0] r;
    case (i)
      4'd0:    r = 6'd11;
      4'd1:    r = 6'd32;
      4'd2:    r = 6'd43;
      4'd3:    r = 6'd31;
      4'd4:    r = 6'd17;
      4'd5:    r = 6'd28;
      4'd6:    r = 6'd39;
      4'd7:    r = 6'd57;
      4'd8:    r = 6'd55;
      4'd9:    r = 6'd54;
      4'd10:   r = 6'd22;
      4'd11:   r = 6'd46;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] end_rot(input logic [3:0] i);
    logic [5:0] r;
    case (i)
      4'd0:    r = 6'd44;
      4'd1:    r = 6'd15;
      4'd2:    r = 6'd34;
      4'd3:    r = 6'd21;
      4'd4:    r = 6'd38;
      4'd5:    r = 6'd33;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd13;
      4'd8:    r = 6'd38;
      4'd9:    r = 6'd53;
      4'd10:   r = 6'd42;
      4'd11:   r = 6'd54;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/spooky_v2_long_hash128.sv */
`timescale 1ns / 1ps
// Channel | Handshake               | Word
// in      | in_valid_i / in_ready_o   | spky_in_t: data_word, byte_count, last
// out     | out_valid_o / out_ready_i | spky_out_t: digest_word, digest_last
// cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i (seed_low, seed_high)
//
// Flow: one word per cycle while the queue has room; a block mixes one step
//   per cycle while the next block's words fill the other bank.
// A last word adds the tail-add steps, the end rounds and the digest load, in that order.
// Reset: rst_ni async, active low; clears control, seed registers and queue.
// Stalls: out_ready_i low holds both digest words and the next digest waits;
//   a full queue drops in_ready_o.
module spooky_v2_long_hash128 #(
  parameter int unsigned QueueDepth = spky_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spky_pkg::spky_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spky_pkg::spky_out_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  logic [63:0] seed_low_q, seed_high_q;

  // front end -> queue
  logic                  push, space;
  spky_pkg::spky_entry_t push_entry;
  // queue -> engine
  logic                  q_valid, q_ready;
  spky_pkg::spky_entry_t q_entry;

  // Config writes; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_low_q  <= 64'd0;
      seed_high_q <= 64'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spky_pkg::CFG_SEED_LOW:  seed_low_q  <= cfg_data_i;
        spky_pkg::CFG_SEED_HIGH: seed_high_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Masks the tail bytes, tracks block position and message boundaries.
  spky_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .space_i    (space),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  spky_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_ready_o (space),
    .wr_entry_i (push_entry),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_entry_o (q_entry)
  );

  // Block buffer, hash state, mix/end sequencer and digest output register.
  spky_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_low_i  (seed_low_q),
    .seed_high_i (seed_high_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_entry_i   (q_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* hdl/spky_front.sv */
`timescale 1ns / 1ps
module spky_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  spky_pkg::spky_in_t    in_word_i,
  input  logic                  space_i,
  output logic                  push_o,
  output spky_pkg::spky_entry_t entry_o
);

  logic [3:0] pos_q, pos_d;
  logic       in_msg_q, in_msg_d;
  logic [3:0] eff;
  logic       accept;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign push_o     = accept;

  always_comb begin
    // non-last words always count as full
    if (!in_word_i.last || (in_word_i.byte_count inside {[4'd8:4'd15]})) begin
      eff = 4'd8;
    end else begin
      eff = in_word_i.byte_count;
    end
    for (int b = 0; b < 8; b++) begin
      entry_o.word[8*b +: 8] = (4'(b) < eff) ? in_word_i.data_word[8*b +: 8] : 8'h00;
    end
    entry_o.pos       = pos_q;
    entry_o.first     = !in_msg_q;
    entry_o.stored    = (eff != 4'd0);
    entry_o.completes = (eff == 4'd8) && (pos_q == spky_pkg::LastStep);
    entry_o.last      = in_word_i.last;
    if (entry_o.completes) begin
      entry_o.tail_words = 4'd0;
      entry_o.tail_len   = 7'd0;
    end else begin
      entry_o.tail_words = pos_q + {3'b000, entry_o.stored};
      entry_o.tail_len   = {pos_q, 3'b000} + {3'b000, eff};
    end
  end

  always_comb begin
    pos_d    = pos_q;
    in_msg_d = in_msg_q;
    if (accept) begin
      if (in_word_i.last) begin
        pos_d    = 4'd0;
        in_msg_d = 1'b0;
      end else begin
        pos_d    = (pos_q == spky_pkg::LastStep) ? 4'd0 : pos_q + 4'd1;
        in_msg_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 4'd0;
      in_msg_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      in_msg_q <= in_msg_d;
    end
  end

endmodule

/* hdl/spky_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spky_fifo #(
  parameter int unsigned Depth = spky_pkg::QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  spky_pkg::spky_entry_t wr_entry_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output spky_pkg::spky_entry_t rd_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  spky_pkg::spky_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_fifo_overfill, cnt_q > CntW'(Depth))

endmodule

/* hdl/spky_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spky_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [63:0]           seed_low_i,
  input  logic [63:0]           seed_high_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  spky_pkg::spky_entry_t q_entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output spky_pkg::spky_out_t   out_word_o
);

  localparam int unsigned NW = spky_pkg::NWords;

  spky_pkg::spky_state_e st_q, st_d;
  logic [3:0]  step_q, step_d;
  logic [1:0]  round_q, round_d;
  logic        bank_q, bank_d;
  logic        mix_bank_q, mix_bank_d;
  logic        fin_pend_q, fin_pend_d;
  logic [1:0]  out_cnt_q, out_cnt_d;
  logic [3:0]  tail_words_q;
  logic [6:0]  tail_len_q;
  logic [63:0] lo_q, hi_q;
  logic [63:0] s_q [NW];
  logic [63:0] s_d [NW];
  logic [63:0] upd [NW];
  logic [63:0] buf_q [2][NW];

  logic        take, needs_engine, load_digest, step_last;
  logic        rd_bank;
  logic [63:0] rd_word, tail_word, t0, e11;

  assign needs_engine = q_entry_i.completes || q_entry_i.last;
  // Plain words may land in the free bank while a block is being mixed.
  assign take = q_valid_i &&
                ((st_q == spky_pkg::ST_IDLE) ||
                 ((st_q == spky_pkg::ST_MIX) && !fin_pend_q && !needs_engine &&
                  !q_entry_i.first));
  assign q_ready_o = take;

  assign step_last = (step_q == spky_pkg::LastStep);
  assign rd_bank   = (st_q == spky_pkg::ST_MIX) ? mix_bank_q : bank_q;
  assign rd_word   = buf_q[rd_bank][step_q];

  always_comb begin
    tail_word = (step_q < tail_words_q) ? rd_word : 64'd0;
    if (step_last) begin
      tail_word = {1'b0, tail_len_q, tail_word[55:0]};
    end
  end

  // Datapath: the state array is rotated by one word per step, so the
  // active word always sits at slot 0.
  always_comb begin
    t0  = s_q[0] + rd_word;
    e11 = s_q[11] + s_q[1];
    for (int j = 0; j < NW; j++) begin
      upd[j] = s_q[j];
    end
    case (st_q)
      spky_pkg::ST_MIX: begin
        upd[0]  = spky_pkg::spky_rotl(t0, spky_pkg::mix_rot(step_q));
        upd[2]  = s_q[2] ^ s_q[10];
        upd[11] = (s_q[11] ^ t0) + s_q[1];
      end
      spky_pkg::ST_TAIL: begin
        upd[0] = s_q[0] + tail_word;
      end
      spky_pkg::ST_END: begin
        upd[11] = e11;
        upd[2]  = s_q[2] ^ e11;
        upd[1]  = spky_pkg::spky_rotl(s_q[1], spky_pkg::end_rot(step_q));
      end
      default: begin
      end
    endcase
    if ((st_q == spky_pkg::ST_MIX) || (st_q == spky_pkg::ST_TAIL) ||
        (st_q == spky_pkg::ST_END)) begin
      for (int j = 0; j < NW - 1; j++) begin
        s_d[j] = upd[j+1];
      end
      s_d[NW-1] = upd[0];
    end else begin
      for (int j = 0; j < NW; j++) begin
        s_d[j] = s_q[j];
      end
    end
    if (take && q_entry_i.first) begin
      for (int g = 0; g < NW / 3; g++) begin
        s_d[3*g]     = seed_low_i;
        s_d[3*g + 1] = seed_high_i;
        s_d[3*g + 2] = spky_pkg::SeedConst;
      end
    end
  end

  // Sequencer
  always_comb begin
    st_d        = st_q;
    step_d      = step_q;
    round_d     = round_q;
    bank_d      = bank_q;
    mix_bank_d  = mix_bank_q;
    fin_pend_d  = fin_pend_q;
    out_cnt_d   = out_cnt_q;
    load_digest = 1'b0;
    if (out_valid_o && out_ready_i) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
    case (st_q)
      spky_pkg::ST_IDLE: begin
        if (take) begin
          if (q_entry_i.completes) begin
            st_d       = spky_pkg::ST_MIX;
            step_d     = 4'd0;
            mix_bank_d = bank_q;
            bank_d     = !bank_q;
            fin_pend_d = q_entry_i.last;
          end else if (q_entry_i.last) begin
            st_d   = spky_pkg::ST_TAIL;
            step_d = 4'd0;
          end
        end
      end
      spky_pkg::ST_MIX: begin
        step_d = step_q + 4'd1;
        if (step_last) begin
          step_d     = 4'd0;
          fin_pend_d = 1'b0;
          st_d       = fin_pend_q ? spky_pkg::ST_TAIL : spky_pkg::ST_IDLE;
        end
      end
      spky_pkg::ST_TAIL: begin
        step_d = step_q + 4'd1;
        if (step_last) begin
          step_d  = 4'd0;
          round_d = 2'd0;
          st_d    = spky_pkg::ST_END;
        end
      end
      spky_pkg::ST_END: begin
        step_d = step_q + 4'd1;
        if (step_last) begin
          step_d  = 4'd0;
          round_d = round_q + 2'd1;
          if (round_q == spky_pkg::LastRound) begin
            st_d = spky_pkg::ST_DONE;
          end
        end
      end
      spky_pkg::ST_DONE: begin
        if (out_cnt_q == 2'd0) begin
          load_digest = 1'b1;
          out_cnt_d   = 2'd2;
          st_d        = spky_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = spky_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= spky_pkg::ST_IDLE;
      step_q     <= 4'd0;
      round_q    <= 2'd0;
      bank_q     <= 1'b0;
      mix_bank_q <= 1'b0;
      fin_pend_q <= 1'b0;
      out_cnt_q  <= 2'd0;
    end else begin
      st_q       <= st_d;
      step_q     <= step_d;
      round_q    <= round_d;
      bank_q     <= bank_d;
      mix_bank_q <= mix_bank_d;
      fin_pend_q <= fin_pend_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NW; j++) begin
      s_q[j] <= s_d[j];
    end
    if (take && q_entry_i.stored) begin
      buf_q[bank_q][q_entry_i.pos] <= q_entry_i.word;
    end
    if (take && q_entry_i.last) begin
      tail_words_q <= q_entry_i.tail_words;
      tail_len_q   <= q_entry_i.tail_len;
    end
    if (load_digest) begin
      lo_q <= s_q[0];
      hi_q <= s_q[1];
    end
  end

  assign out_valid_o            = (out_cnt_q != 2'd0);
  assign out_word_o.digest_word = (out_cnt_q == 2'd2) ? lo_q : hi_q;
  assign out_word_o.digest_last = (out_cnt_q == 2'd1);

  `ASSERT_CLK(a_mix_other_bank, (st_q == spky_pkg::ST_MIX) |-> (mix_bank_q != bank_q))
  `ASSERT_CLK(a_fin_pend_in_mix, fin_pend_q |-> (st_q == spky_pkg::ST_MIX))
  `ASSERT_CLK(a_done_waits, (st_q == spky_pkg::ST_DONE && out_valid_o) |=> st_q == spky_pkg::ST_DONE)
  `ASSERT_NEVER(a_out_cnt_range, out_cnt_q == 2'd3)

endmodule

/* tb/sv/spooky_v2_long_hash128_test.sv */
`timescale 1ns / 1ps
module spooky_v2_long_hash128_test;
  import spky_pkg::*;

  // Run limits. Worst case is ~1750 one-word messages, each paying for
  // finalization plus output stalls and sender gaps.
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 64;   // tail add + end rounds + load
  localparam int unsigned HoldCycles  = 600;  // long receiver hold-off
  localparam int unsigned PhaseWords  = 350;  // random words per seed setting
  localparam int unsigned BlockWords  = 12;   // 96-byte block
  localparam logic [63:0] StartConst  = 64'hdeadbeefdeadbeef;

  // Rotation amounts of the block mix and of the end round, per lane.
  localparam int unsigned MixShift [12] = '{11, 32, 43, 31, 17, 28, 39, 57, 55, 54, 22, 46};
  localparam int unsigned FinShift [12] = '{44, 15, 34, 21, 38, 33, 10, 13, 38, 53, 42, 54};

  // Receiver stall patterns.
  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  // Scoreboard: keeps its own hash state and seed copy, and the digest words
  // still owed by the block, oldest first.
  class digest_scoreboard;
    logic [63:0] seed_lo;
    logic [63:0] seed_hi;
    logic [63:0] hash_st[12];
    logic [63:0] block_words[12];
    int unsigned fill;          // words held in the current block
    bit          open;          // a message is in progress
    spky_out_t   digest_q[$];
    int unsigned errors;

    function new();
      seed_lo = '0;
      seed_hi = '0;
      fill    = 0;
      open    = 1'b0;
      errors  = 0;
    endfunction

    function void set_seed(spky_cfg_e idx, logic [63:0] value);
      case (idx)
        CFG_SEED_LOW:  seed_lo = value;
        CFG_SEED_HIGH: seed_hi = value;
        default: ;
      endcase
    endfunction

    function logic [63:0] rot_left(logic [63:0] x, int unsigned r);
      return (x << r) | (x >> (64 - r));
    endfunction

    function void mix_block();
      int unsigned a, b, c, d;
      for (int i = 0; i < 12; i++) begin
        a = (i + 1) % 12;
        b = (i + 2) % 12;
        c = (i + 10) % 12;
        d = (i + 11) % 12;
        hash_st[i] += block_words[i];
        hash_st[b] ^= hash_st[c];
        hash_st[d] ^= hash_st[i];
        hash_st[i] = rot_left(hash_st[i], MixShift[i]);
        hash_st[d] += hash_st[a];
      end
    endfunction

    function void end_round();
      int unsigned a, b, d;
      for (int i = 0; i < 12; i++) begin
        a = (i + 1) % 12;
        b = (i + 2) % 12;
        d = (i + 11) % 12;
        hash_st[d] += hash_st[a];
        hash_st[b] ^= hash_st[d];
        hash_st[a] = rot_left(hash_st[a], FinShift[i]);
      end
    endfunction

    // Fold one accepted input word into the state; a last word queues the
    // two digest words.
    function void note_word(spky_in_t w);
      logic [63:0] data;
      int unsigned cnt;
      int unsigned tail_len;
      spky_out_t   lo_word;
      spky_out_t   hi_word;
      if (!open) begin
        for (int i = 0; i < 12; i += 3) begin
          hash_st[i]     = seed_lo;
          hash_st[i + 1] = seed_hi;
          hash_st[i + 2] = StartConst;
        end
        fill = 0;
        open = 1'b1;
      end
      // Non-last words are always full; oversized counts clamp to 8.
      cnt = w.byte_count;
      if (cnt > 8 || !w.last) cnt = 8;
      data = w.data_word;
      if (cnt < 8) data &= (64'd1 << (8 * cnt)) - 64'd1;
      if (cnt == 8) begin
        block_words[fill] = data;
        fill++;
        if (fill == BlockWords) begin
          mix_block();
          fill = 0;
        end
        if (!w.last) return;
        cnt  = 0;
        data = '0;
      end
      // Tail: zero pad, length in the top byte of the block.
      tail_len = fill * 8 + cnt;
      if (cnt > 0) begin
        block_words[fill] = data;
        fill++;
      end
      for (int i = fill; i < 12; i++) block_words[i] = '0;
      block_words[11][63:56] = 8'(tail_len);
      for (int i = 0; i < 12; i++) hash_st[i] += block_words[i];
      repeat (3) end_round();
      lo_word.digest_word = hash_st[0];
      lo_word.digest_last = 1'b0;
      hi_word.digest_word = hash_st[1];
      hi_word.digest_last = 1'b1;
      digest_q.push_back(lo_word);
      digest_q.push_back(hi_word);
      fill = 0;
      open = 1'b0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] digest mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_digest(spky_out_t got);
      spky_out_t want;
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("word %h last %b with nothing pending",
                                  got.digest_word, got.digest_last));
        return;
      end
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word)
        report_mismatch($sformatf("digest_word %h, want %h",
                                  got.digest_word, want.digest_word));
      if (got.digest_last !== want.digest_last)
        report_mismatch($sformatf("digest_last %b, want %b",
                                  got.digest_last, want.digest_last));
    endtask
  endclass

  // Clock, reset and block ports; every input known from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  spky_in_t    in_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  spky_out_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_SEED_LOW;
  logic [63:0] cfg_data_i  = '0;

  digest_scoreboard sb = new();

  // Sender idling: bursts of random length separated by random gaps.
  bit          gaps_on;
  int unsigned burst_left;
  int unsigned phase_words;

  // Receiver state, owned by the receiver process. hold_req is raised once
  // by the stimulus to start the long hold-off.
  bit          hold_req = 1'b0;
  bit          hold_started = 1'b0;
  int unsigned hold_left = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_mode_left = 0;

  int unsigned cycle_count = 0;

  always #1 clk_i = ~clk_i;

  spooky_v2_long_hash128 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic logic [63:0] rand_data();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic spky_in_t make_word(logic [63:0] data, logic [3:0] cnt, logic last);
    spky_in_t w;
    w.data_word  = data;
    w.byte_count = cnt;
    w.last       = last;
    return w;
  endfunction

  // Offer one word and hold it until taken. Valid stays up into the next
  // word unless a gap starts here, so it is never dropped and raised in
  // the same step.
  task automatic send_word(spky_in_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    phase_words++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // A message of n_words words; the earlier words are mostly full, a noisy
  // message also carries short counts that must read as full.
  task automatic send_message(int unsigned n_words, logic [3:0] last_cnt, bit noisy);
    logic [3:0] cnt;
    for (int k = 1; k < n_words; k++) begin
      cnt = 4'd8;
      if (noisy && $urandom_range(0, 3) == 0) cnt = 4'($urandom_range(0, 15));
      send_word(make_word(rand_data(), cnt, 1'b0));
    end
    send_word(make_word(rand_data(), last_cnt, 1'b1));
  endtask

  // Length mix: mostly short, some across several blocks, a few long.
  task automatic random_message();
    int unsigned n_words;
    int unsigned pick;
    logic [3:0]  last_cnt;
    pick = $urandom_range(0, 9);
    if (pick < 6)      n_words = $urandom_range(1, 4);
    else if (pick < 9) n_words = $urandom_range(5, 26);
    else               n_words = $urandom_range(27, 40);
    if ($urandom_range(0, 9) == 0) last_cnt = 4'($urandom_range(9, 15));
    else                           last_cnt = 4'($urandom_range(0, 8));
    send_message(n_words, last_cnt, $urandom_range(0, 4) == 0);
  endtask

  // Seed write; only issued while the block is idle.
  task automatic write_seeds(logic [63:0] lo, logic [63:0] hi);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_SEED_LOW;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_seed(CFG_SEED_LOW, lo);
    cfg_index_i <= CFG_SEED_HIGH;
    cfg_data_i  <= hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_seed(CFG_SEED_HIGH, hi);
    cfg_valid_i <= 1'b0;
  endtask

  // Let every pending digest come out, then give the engine time to settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver: check the word taken at this edge, then pick ready for the
  // next cycle. Stall pattern is picked anew when its run counter runs out;
  // the long hold-off is counted here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_digest(out_word_o);
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** spooky_v2_long_hash128: FAILED **");
    $finish;
  end

  initial begin
    logic [63:0] seed_lo;
    logic [63:0] seed_hi;
    gaps_on     = 1'b1;
    burst_left  = 0;
    phase_words = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words, reset seeds (both zero).
    // Empty message; all-ones data must be ignored.
    send_word(make_word('1, 4'd0, 1'b1));
    // One byte out of an all-ones word.
    send_word(make_word('1, 4'd1, 1'b1));
    // Seven bytes.
    send_word(make_word(64'h0123456789abcdef, 4'd7, 1'b1));
    // Oversized counts on a last word read as 8.
    send_word(make_word('1, 4'd15, 1'b1));
    send_word(make_word(64'h8000000000000001, 4'd9, 1'b1));
    // Short count on a non-last word still counts as a full word.
    send_word(make_word('1, 4'd0, 1'b0));
    send_word(make_word('0, 4'd8, 1'b1));
    // Block ends on the last word: 12 full words, empty tail.
    for (int k = 1; k < BlockWords; k++) send_word(make_word(rand_data(), 4'd8, 1'b0));
    send_word(make_word('1, 4'd8, 1'b1));
    drain();

    // Random phases, one seed setting each, extremes first.
    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin seed_lo = '1; seed_hi = '1; end
        2: begin seed_lo = '0; seed_hi = '1; end
        3: begin seed_lo = '1; seed_hi = '0; end
        default: begin seed_lo = rand_data(); seed_hi = rand_data(); end
      endcase
      write_seeds(seed_lo, seed_hi);
      phase_words = 0;
      gaps_on     = (phase % 2) == 1;
      burst_left  = $urandom_range(1, 30);
      if (phase == 2) begin
        // Receiver holds off while one-word messages go in back to back,
        // so digests back up and the input queue fills.
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++)
          send_word(make_word(rand_data(), 4'($urandom_range(0, 8)), 1'b1));
      end
      while (phase_words < PhaseWords) random_message();
      drain();
    end

    if (sb.errors == 0 && sb.digest_q.size() == 0) begin
      $display("** spooky_v2_long_hash128: PASSED **");
    end else begin
      $display("** spooky_v2_long_hash128: FAILED **");
    end
    $finish;
  end

endmodule
